/* rtl/core/bevq_pkg.sv */
// Package for the button event qualifier: payload structs, state structs,
// configuration codes and reset values. No dependencies.
package bevq_pkg;

  localparam int CH_W    = 9;
  localparam int MS_W    = 16;
  localparam int CLASS_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [MS_W-1:0] DCLICK_RST     = 16'd250;
  localparam logic [MS_W-1:0] LONG_PRESS_RST = 16'd700;
  localparam logic [MS_W-1:0] DELTA_LIM_RST  = 16'd1000;
  localparam logic [MS_W-1:0] DELTA_FB_RST   = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DCLICK_TIME     = 3'd0,
    CFG_LONG_PRESS_TIME = 3'd1,
    CFG_DELTA_LIMIT     = 3'd2,
    CFG_DELTA_FALLBACK  = 3'd3,
    CFG_EVENTS_SUPP     = 3'd4
  } cfg_idx_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_UP       = 2'd0,
    CLASS_DOUBLE   = 2'd1,
    CLASS_DRAGGED  = 2'd2,
    CLASS_RELEASED = 2'd3
  } btn_class_t;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_NONE   = 2'd2
  } chan_kind_t;

  typedef struct packed {
    logic [MS_W-1:0] dclick;
    logic [MS_W-1:0] long_press;
    logic [MS_W-1:0] delta_limit;
    logic [MS_W-1:0] delta_fallback;
    logic            suppress;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            level;
    logic [MS_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel_out;
    logic               is_down;
    logic               pressed;
    logic               released;
    logic               held_long;
    logic               double_clicked;
    logic [CLASS_W-1:0] button_class;
    logic [MS_W-1:0]    hold_time_ms;
  } out_item_t;

  // Per-channel state shared by keys and buttons
  typedef struct packed {
    logic            level;
    logic            long_flag;
    logic [MS_W-1:0] hold;
  } chan_state_t;

  typedef struct packed {
    chan_state_t     chan;
    logic [MS_W-1:0] countdown;
  } btn_state_t;

endpackage

/* rtl/core/bevq_stream_if.sv */
// Valid/ready stream interface carrying one payload struct per beat.
// Payload type comes from bevq_pkg at the point of use.
interface bevq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/bevq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bevq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* rtl/core/bevq_btn_bank.sv */
// Pointer button state held in flops: level, hold timer, long flag, countdown.
// Uses bevq_pkg::btn_state_t.
module bevq_btn_bank #(
  parameter int BUTTONS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [(BUTTONS > 1 ? $clog2(BUTTONS) : 1)-1:0] rd_idx,
  output bevq_pkg::btn_state_t                          rd_state,
  input  logic                                          we,
  input  logic [(BUTTONS > 1 ? $clog2(BUTTONS) : 1)-1:0] wr_idx,
  input  bevq_pkg::btn_state_t                          wr_state
);
  bevq_pkg::btn_state_t btn_r [BUTTONS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUTTONS; i++) begin
        btn_r[i] <= '0;
      end
    end else if (we) begin
      btn_r[wr_idx] <= wr_state;
    end
  end

  assign rd_state = btn_r[rd_idx];
endmodule

/* rtl/core/bevq_update.sv */
// Per-sample update: elapsed fallback, hold timer, long flag, double-click
// countdown, class and gated flags. Combinational; uses bevq_pkg.
module bevq_update (
  input  bevq_pkg::cfg_t          cfg,
  input  bevq_pkg::in_item_t      item,
  input  bevq_pkg::chan_kind_t    kind,
  input  bevq_pkg::chan_state_t   old_chan,
  input  logic [bevq_pkg::MS_W-1:0] old_cd,
  output bevq_pkg::chan_state_t   new_chan,
  output logic [bevq_pkg::MS_W-1:0] new_cd,
  output bevq_pkg::out_item_t     result
);
  logic [bevq_pkg::MS_W-1:0] d;
  logic [bevq_pkg::MS_W:0]   hold_sum;
  logic [bevq_pkg::MS_W-1:0] hold_sat;
  logic [bevq_pkg::MS_W-1:0] cd_dec;
  logic                      is_btn;
  logic                      cd_live;
  logic                      old_lvl;
  logic                      en;
  bevq_pkg::btn_class_t      cls;

  always_comb begin
    d        = (item.elapsed_ms > cfg.delta_limit) ? cfg.delta_fallback : item.elapsed_ms;
    old_lvl  = old_chan.level;
    hold_sum = {1'b0, old_chan.hold} + {1'b0, d};
    hold_sat = hold_sum[bevq_pkg::MS_W] ? '1 : hold_sum[bevq_pkg::MS_W-1:0];

    new_chan.level     = item.level;
    new_chan.hold      = old_lvl ? hold_sat : '0;
    new_chan.long_flag = old_lvl & (old_chan.long_flag | (hold_sat >= cfg.long_press));

    // countdown runs down first, then reloads while the button was held
    cd_dec  = (old_cd > d) ? old_cd - d : '0;
    new_cd  = old_lvl ? cfg.dclick : cd_dec;
    is_btn  = (kind == bevq_pkg::KIND_BUTTON);
    cd_live = is_btn && (new_cd != '0);

    if (!is_btn) begin
      cls = bevq_pkg::CLASS_UP;
    end else if (item.level) begin
      cls = (!old_lvl && cd_live) ? bevq_pkg::CLASS_DOUBLE : bevq_pkg::CLASS_DRAGGED;
    end else if (old_lvl) begin
      cls = bevq_pkg::CLASS_RELEASED;
    end else begin
      cls = bevq_pkg::CLASS_UP;
    end

    en = !cfg.suppress;
    result                = '0;
    result.channel_out    = item.channel;
    if (kind != bevq_pkg::KIND_NONE) begin
      result.is_down        = en & item.level;
      result.pressed        = en & item.level & ~old_lvl;
      result.released       = en & ~item.level & old_lvl;
      result.held_long      = en & item.level & new_chan.long_flag;
      result.double_clicked = en & item.level & ~old_lvl & cd_live;
      result.button_class   = cls;
      result.hold_time_ms   = new_chan.hold;
    end
  end
endmodule

/* rtl/core/button_event_qualifier.sv */
// Top level of the button event qualifier: config registers, input stage,
// key state RAM, button flops and result register. Uses bevq_pkg,
// bevq_stream_if, bevq_ram, bevq_btn_bank and bevq_update.
//
//   port       dir   beat contents
//   in_beat    sink  channel, level, elapsed_ms
//   out_beat   src   channel_out, flags, button_class, hold_time_ms
//   cfg_*      in    write enable, register index, 16-bit data
//
// One beat per cycle while out is not stalled. Key state sits in a RAM with
// registered read: read as a beat is accepted, computed and written back
// in stage 1, then registered in the output register. A same-key write in
// the cycle of a read is forwarded. Per-key valid bits clear at reset, so
// there is no clearing pass. A stalled output register holds the input
// stage; in_beat.ready drops only when both stages are full and out stalls.
module button_event_qualifier #(
  parameter int KEYS    = 256,
  parameter int BUTTONS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bevq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bevq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  bevq_stream_if.sink                     in_beat,
  bevq_stream_if.source                   out_beat
);
  localparam int KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int BTN_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [bevq_pkg::CH_W-1:0] KEYS_CH = bevq_pkg::CH_W'(KEYS);
  localparam logic [bevq_pkg::CH_W-1:0] CHANS_CH = bevq_pkg::CH_W'(KEYS + BUTTONS);

  // ---------------- configuration registers ----------------
  bevq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dclick         <= bevq_pkg::DCLICK_RST;
      cfg_r.long_press     <= bevq_pkg::LONG_PRESS_RST;
      cfg_r.delta_limit    <= bevq_pkg::DELTA_LIM_RST;
      cfg_r.delta_fallback <= bevq_pkg::DELTA_FB_RST;
      cfg_r.suppress       <= 1'b0;
    end else if (cfg_we) begin
      unique case (bevq_pkg::cfg_idx_t'(cfg_idx))
        bevq_pkg::CFG_DCLICK_TIME:     cfg_r.dclick         <= cfg_wdata;
        bevq_pkg::CFG_LONG_PRESS_TIME: cfg_r.long_press     <= cfg_wdata;
        bevq_pkg::CFG_DELTA_LIMIT:     cfg_r.delta_limit    <= cfg_wdata;
        bevq_pkg::CFG_DELTA_FALLBACK:  cfg_r.delta_fallback <= cfg_wdata;
        bevq_pkg::CFG_EVENTS_SUPP:     cfg_r.suppress       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake and stage control ----------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_beat.ready);
  assign in_beat.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_beat.valid && in_beat.ready;

  // ---------------- stage 1: item, state read ----------------
  bevq_pkg::in_item_t    s1_item_r;
  bevq_pkg::chan_kind_t  s1_kind;
  logic                  s1_fwd_r;
  bevq_pkg::chan_state_t fwd_r;
  logic [KEYS-1:0]       kvalid_r;
  logic [KEY_AW-1:0]     s1_kaddr;
  logic [bevq_pkg::CH_W-1:0] s1_boff;
  logic [BTN_W-1:0]      s1_bidx;
  logic [$bits(bevq_pkg::chan_state_t)-1:0] ram_rdata;
  bevq_pkg::chan_state_t key_old;
  bevq_pkg::chan_state_t chan_old;
  bevq_pkg::btn_state_t  btn_rd;
  bevq_pkg::btn_state_t  btn_wr;
  bevq_pkg::chan_state_t chan_new;
  logic [bevq_pkg::MS_W-1:0] cd_new;
  bevq_pkg::out_item_t   res;
  logic                  key_wr;
  logic                  btn_wr_en;
  logic                  in_is_key;

  always_comb begin
    if (s1_item_r.channel < KEYS_CH) begin
      s1_kind = bevq_pkg::KIND_KEY;
    end else if (s1_item_r.channel < CHANS_CH) begin
      s1_kind = bevq_pkg::KIND_BUTTON;
    end else begin
      s1_kind = bevq_pkg::KIND_NONE;
    end
  end

  assign s1_kaddr  = s1_item_r.channel[KEY_AW-1:0];
  assign s1_boff   = s1_item_r.channel - KEYS_CH;
  assign s1_bidx   = s1_boff[BTN_W-1:0];
  assign in_is_key = (in_beat.data.channel < KEYS_CH);

  // forwarded write wins, then RAM data, then the reset value for unwritten keys
  always_comb begin
    if (s1_fwd_r) begin
      key_old = fwd_r;
    end else if (kvalid_r[s1_kaddr]) begin
      key_old = bevq_pkg::chan_state_t'(ram_rdata);
    end else begin
      key_old = '0;
    end
    chan_old = (s1_kind == bevq_pkg::KIND_BUTTON) ? btn_rd.chan : key_old;
  end

  assign key_wr    = s1_adv && (s1_kind == bevq_pkg::KIND_KEY);
  assign btn_wr_en = s1_adv && (s1_kind == bevq_pkg::KIND_BUTTON);
  assign btn_wr.chan      = chan_new;
  assign btn_wr.countdown = cd_new;

  bevq_ram #(
    .WIDTH ($bits(bevq_pkg::chan_state_t)),
    .DEPTH (KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_wr),
    .waddr (s1_kaddr),
    .wdata (chan_new),
    .re    (in_acc && in_is_key),
    .raddr (in_beat.data.channel[KEY_AW-1:0]),
    .rdata (ram_rdata)
  );

  bevq_btn_bank #(
    .BUTTONS (BUTTONS)
  ) u_btn_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (s1_bidx),
    .rd_state (btn_rd),
    .we       (btn_wr_en),
    .wr_idx   (s1_bidx),
    .wr_state (btn_wr)
  );

  bevq_update u_update (
    .cfg      (cfg_r),
    .item     (s1_item_r),
    .kind     (s1_kind),
    .old_chan (chan_old),
    .old_cd   (btn_rd.countdown),
    .new_chan (chan_new),
    .new_cd   (cd_new),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
      kvalid_r   <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        // RAM read this edge misses the write of the same key at this edge
        s1_fwd_r   <= key_wr && (in_beat.data.channel == s1_item_r.channel);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (key_wr) begin
        kvalid_r[s1_kaddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_beat.data;
      fwd_r     <= chan_new;
    end
  end

  // ---------------- result register ----------------
  bevq_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_beat.valid = out_valid_r;
  assign out_beat.data  = out_data_r;

  // ---------------- assertions ----------------
  a_fwd_is_key: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_fwd_r |-> s1_kind == bevq_pkg::KIND_KEY)
    else $error("forwarded key state on a non-key item");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result lost between stage 1 and output register");

  a_key_no_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.channel_out < KEYS_CH) |->
      out_data_r.button_class == bevq_pkg::CLASS_UP && !out_data_r.double_clicked)
    else $error("key result carries a button class or double click");

  a_edges_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.pressed && out_data_r.released))
    else $error("pressed and released in one result");
endmodule

/* bench/button_event_qualifier_test.sv */
// Self-checking bench for button_event_qualifier: scan beats in, one result beat out.
// Needs bevq_pkg, bevq_stream_if and the block itself; a built-in predictor gives
// the expected results.
module button_event_qualifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bevq_pkg::*;

  localparam int KEYS     = 256;
  localparam int BUTTONS  = 8;
  localparam int CHANNELS = KEYS + BUTTONS;

  localparam int PHASES          = 8;
  localparam int SCANS_PER_PHASE = 195;
  localparam int LONG_HOLD       = 200;     // cycles of forced output back-pressure
  localparam int HOLD_SPACING    = 600;     // result beats between forced holds
  localparam int TAIL_CYCLES     = 8;       // a result trails its scan through stage 1 and the output register
  localparam int CYCLE_LIMIT     = 500000;
  localparam int MAX_REPORTS     = 10;

  // indexes past the last mapped register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_EVENTS_SUPP + 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNMAPPED  = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bevq_stream_if #(.payload_t(in_item_t))  in_if ();
  bevq_stream_if #(.payload_t(out_item_t)) out_if ();

  button_event_qualifier #(
    .KEYS    (KEYS),
    .BUTTONS (BUTTONS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_beat   (in_if),
    .out_beat  (out_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the block's registers and per-channel
  // memories. Class is recomputed each scan, so it needs no store here.
  // ---------------------------------------------------------------------------
  cfg_t        cfg_now;
  logic        level_mem     [CHANNELS];
  logic [15:0] hold_mem      [CHANNELS];
  logic        long_mem      [CHANNELS];
  logic [15:0] countdown_mem [BUTTONS];

  // Stimulus side
  in_item_t    scan_q[$];          // scans waiting for the driver
  out_item_t   result_q[$];        // predicted results, oldest first
  logic        gen_level [CHANNELS];
  int          hot_keys [4];
  int unsigned scans_queued = 0;

  // Bookkeeping written by the monitor at the rising edge
  int unsigned scans_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  logic        in_took      = 1'b0;

  // Sender and receiver pacing
  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 300;
  int unsigned pat_left     = 0;
  int unsigned pat_pos      = 0;
  logic [15:0] ready_mask   = 16'hFFFF;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict the result of one accepted scan and advance the predictor state.
  function automatic out_item_t predict_scan(in_item_t s);
    out_item_t   r;
    int          ch;
    int          b;
    logic [15:0] d;
    logic [16:0] sum;
    logic        was_down;
    logic        live;
    logic        open;
    btn_class_t  cls;
    r = '0;
    r.channel_out = s.channel;
    ch = s.channel;
    if (ch >= CHANNELS) return r;   // out of range: echo only, state untouched

    // implausible elapsed time is swapped for the fallback
    d = (s.elapsed_ms > cfg_now.delta_limit) ? cfg_now.delta_fallback : s.elapsed_ms;
    was_down = level_mem[ch];
    live = 1'b0;
    cls = CLASS_UP;

    // double-click window runs down first; any scan that finds the button
    // down re-arms it
    if (ch >= KEYS) begin
      b = ch - KEYS;
      if (was_down)
        countdown_mem[b] = cfg_now.dclick;
      else if (countdown_mem[b] > d)
        countdown_mem[b] = countdown_mem[b] - d;
      else
        countdown_mem[b] = '0;
      live = countdown_mem[b] != '0;
    end

    if (was_down) begin
      sum = 17'(hold_mem[ch]) + 17'(d);
      hold_mem[ch] = sum[16] ? 16'hFFFF : sum[15:0];
      if (hold_mem[ch] >= cfg_now.long_press) long_mem[ch] = 1'b1;
    end else begin
      hold_mem[ch] = '0;
      long_mem[ch] = 1'b0;
    end
    level_mem[ch] = s.level;

    if (ch >= KEYS) begin
      if (s.level)
        cls = (!was_down && live) ? CLASS_DOUBLE : CLASS_DRAGGED;
      else if (was_down)
        cls = CLASS_RELEASED;
    end

    // suppression gates the five flags only
    open = !cfg_now.suppress;
    r.is_down        = open && s.level;
    r.pressed        = open && s.level && !was_down;
    r.released       = open && !s.level && was_down;
    r.held_long      = open && s.level && long_mem[ch];
    r.double_clicked = open && s.level && !was_down && live;
    r.button_class   = cls;
    r.hold_time_ms   = hold_mem[ch];
    return r;
  endfunction

  task automatic queue_scan(input int ch, input logic lvl, input logic [15:0] ms);
    in_item_t s;
    s.channel    = CH_W'(ch);
    s.level      = lvl;
    s.elapsed_ms = ms;
    if (ch < CHANNELS) gen_level[ch] = lvl;
    scan_q.push_back(s);
    scans_queued++;
  endtask

  // Elapsed times: mostly short steps so double clicks and long presses happen,
  // plus zero, the limit boundary and the full 16-bit range.
  function automatic logic [15:0] pick_elapsed();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return 16'($urandom_range(1, 150));
    if (r < 90) return 16'($urandom);
    if (r < 96) begin
      v = int'(cfg_now.delta_limit) + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
    end
    return 16'hFFFF - 16'($urandom_range(0, 3));
  endfunction

  // Random scans: buttons and a few hot keys dominate so press/hold/release
  // sequences build up; the rest spreads over all keys and invalid channels.
  task automatic queue_random(input int count);
    int  pick;
    int  ch;
    logic lvl;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      ch = KEYS + $urandom_range(0, BUTTONS - 1);
      else if (pick < 83) ch = hot_keys[$urandom_range(0, 3)];
      else if (pick < 94) ch = $urandom_range(0, KEYS - 1);
      else                ch = $urandom_range(CHANNELS, (1 << CH_W) - 1);
      if (ch < CHANNELS)
        lvl = ($urandom_range(0, 99) < 40) ? !gen_level[ch] : gen_level[ch];
      else
        lvl = 1'($urandom_range(0, 1));
      queue_scan(ch, lvl, pick_elapsed());
    end
  endtask

  // Register write, only ever issued while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DCLICK_TIME:     cfg_now.dclick         = val;
      CFG_LONG_PRESS_TIME: cfg_now.long_press     = val;
      CFG_DELTA_LIMIT:     cfg_now.delta_limit    = val;
      CFG_DELTA_FALLBACK:  cfg_now.delta_fallback = val;
      CFG_EVENTS_SUPP:     cfg_now.suppress       = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Idle once every queued scan is taken and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (scans_taken != scans_queued || result_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents scans from scan_q in bursts with idle gaps. A beat that
  // is offered stays put until the monitor sees it accepted.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    in_item_t nxt;
    logic     nvalid;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      nvalid = in_if.valid;
      nxt    = in_if.data;
      if (!in_if.valid || in_took) begin
        nvalid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (scan_q.size() > 0) begin
          nxt    = scan_q.pop_front();
          nvalid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // now and then a long burst with no gap at all
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(20, 60);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 24);
              gap_left   = $urandom_range(0, 8);
            end
          end
        end
      end
      in_if.valid <= nvalid;
      in_if.data  <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a 16-bit pattern that is re-picked every so often.
  // Every HOLD_SPACING results it also drops ready for a forced hold so the
  // pipeline fills and in_beat.ready has to fall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left    = LONG_HOLD;
        next_hold_at = next_hold_at + HOLD_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          case ($urandom_range(0, 4))
            0: ready_mask = 16'hFFFF;
            1: ready_mask = 16'($urandom);
            2: ready_mask = 16'h0101;
            3: ready_mask = 16'h5555;
            default: ready_mask = 16'hFFF0;
          endcase
          if (ready_mask == '0) ready_mask = 16'h0001;
          pat_left = $urandom_range(16, 160);
        end
        pat_left--;
        out_if.ready <= ready_mask[pat_pos];
        pat_pos = (pat_pos + 1) % 16;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result beats against the oldest prediction, then predict
  // for any scan beat accepted at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    in_took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        results_seen <= results_seen + 1;
        if (result_q.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("unexpected result beat, channel %0d", got.channel_out);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            if (errors < MAX_REPORTS)
              $display({"mismatch ch %0d/%0d down %b/%b press %b/%b rel %b/%b ",
                        "long %b/%b dbl %b/%b class %0d/%0d hold %0d/%0d (exp/got)"},
                       want.channel_out, got.channel_out, want.is_down, got.is_down,
                       want.pressed, got.pressed, want.released, got.released,
                       want.held_long, got.held_long,
                       want.double_clicked, got.double_clicked,
                       want.button_class, got.button_class,
                       want.hold_time_ms, got.hold_time_ms);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        result_q.push_back(predict_scan(in_if.data));
        scans_taken <= scans_taken + 1;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed scans at reset settings, then phases of
  // random scans, each under its own register settings.
  // ---------------------------------------------------------------------------
  initial begin : main
    cfg_t nxt_cfg;
    int   p;
    // every block input known from time zero
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;

    cfg_now.dclick         = DCLICK_RST;
    cfg_now.long_press     = LONG_PRESS_RST;
    cfg_now.delta_limit    = DELTA_LIM_RST;
    cfg_now.delta_fallback = DELTA_FB_RST;
    cfg_now.suppress       = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      level_mem[i] = 1'b0;
      hold_mem[i]  = '0;
      long_mem[i]  = 1'b0;
      gen_level[i] = 1'b0;
    end
    for (int i = 0; i < BUTTONS; i++) countdown_mem[i] = '0;
    hot_keys[0] = 0;
    hot_keys[1] = KEYS - 1;
    hot_keys[2] = $urandom_range(1, KEYS - 2);
    hot_keys[3] = $urandom_range(1, KEYS - 2);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: dclick 250, long press 700, limit 1000, fallback 50
    queue_scan(0, 1'b1, 16'd0);           // key press
    queue_scan(0, 1'b1, 16'hFFFF);        // above limit -> fallback
    queue_scan(0, 1'b1, 16'd1000);        // exactly at limit, kept; goes long
    queue_scan(0, 1'b0, 16'd10);          // release
    queue_scan(0, 1'b0, 16'd5);           // stays up, state cleared
    queue_scan(KEYS - 1, 1'b1, 16'd0);
    queue_scan(KEYS - 1, 1'b1, 16'd699);  // one short of long press
    queue_scan(KEYS - 1, 1'b1, 16'd1);    // reaches long press
    queue_scan(KEYS - 1, 1'b0, 16'd0);
    queue_scan(KEYS, 1'b1, 16'd0);        // first button press: dragged
    queue_scan(KEYS, 1'b0, 16'd20);       // released, window armed
    queue_scan(KEYS, 1'b1, 16'd100);      // inside window: double click
    queue_scan(KEYS, 1'b1, 16'd30);       // held: dragged
    queue_scan(KEYS, 1'b0, 16'd30);
    queue_scan(KEYS, 1'b0, 16'd250);      // window runs out exactly
    queue_scan(KEYS, 1'b1, 16'd0);        // late press, no double
    queue_scan(CHANNELS - 1, 1'b1, 16'd0);
    queue_scan(CHANNELS - 1, 1'b0, 16'd0);
    queue_scan(CHANNELS - 1, 1'b1, 16'd249);   // one ms left in window
    queue_scan(CHANNELS - 1, 1'b0, 16'd0);
    queue_scan(CHANNELS - 1, 1'b1, 16'hFFFF);  // fallback keeps it in window
    queue_scan(CHANNELS, 1'b1, 16'hFFFF);      // first invalid channel
    queue_scan((1 << CH_W) - 1, 1'b1, 16'd0);  // top invalid channel
    queue_scan(300, 1'b0, 16'd1234);
    queue_scan(CHANNELS - 1, 1'b0, 16'd0);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          // wide window, instant long press, every nonzero step implausible
          nxt_cfg.dclick         = 16'hFFFF;
          nxt_cfg.long_press     = 16'h0000;
          nxt_cfg.delta_limit    = 16'h0000;
          nxt_cfg.delta_fallback = 16'hFFFF;
          nxt_cfg.suppress       = 1'b0;
        end
        1: begin
          // no window, long press never before saturation, flags suppressed
          nxt_cfg.dclick         = 16'h0000;
          nxt_cfg.long_press     = 16'hFFFF;
          nxt_cfg.delta_limit    = 16'hFFFF;
          nxt_cfg.delta_fallback = 16'h0000;
          nxt_cfg.suppress       = 1'b1;
        end
        2: begin
          nxt_cfg.dclick         = 16'hFFFF;
          nxt_cfg.long_press     = 16'hFFFF;
          nxt_cfg.delta_limit    = 16'hFFFF;
          nxt_cfg.delta_fallback = 16'hFFFF;
          nxt_cfg.suppress       = 1'b0;
        end
        default: begin
          nxt_cfg.dclick         = 16'($urandom_range(1, 400));
          nxt_cfg.long_press     = 16'($urandom_range(1, 1500));
          nxt_cfg.delta_limit    = 16'($urandom_range(50, 2000));
          nxt_cfg.delta_fallback = 16'($urandom_range(0, 300));
          nxt_cfg.suppress       = ($urandom_range(0, 3) == 0);
        end
      endcase
      write_reg(CFG_DCLICK_TIME, nxt_cfg.dclick);
      write_reg(CFG_LONG_PRESS_TIME, nxt_cfg.long_press);
      write_reg(CFG_DELTA_LIMIT, nxt_cfg.delta_limit);
      write_reg(CFG_DELTA_FALLBACK, nxt_cfg.delta_fallback);
      write_reg(CFG_EVENTS_SUPP, CFG_DATA_W'(nxt_cfg.suppress));
      // stray writes to unmapped indexes must change nothing
      if (p == 2 || p == 5)
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_UNMAPPED)),
                  16'($urandom));
      queue_random(SCANS_PER_PHASE);
      wait_drained();
    end

    // let any stray late beat show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bevq_pkg.sv
rtl/core/bevq_stream_if.sv
rtl/core/bevq_ram.sv
rtl/core/bevq_btn_bank.sv
rtl/core/bevq_update.sv
rtl/core/button_event_qualifier.sv
bench/button_event_qualifier_test.sv
